// File: hw/rtl/pfcs_pkg.sv
// ----------------------------------------------------------------------------
// pfcs_pkg: shared types and constants of the PFC egress scheduler
// Holds the queue sizing, the event and status codes, the payload structs of
// both channels and the command and status bundles between control and data.
// ----------------------------------------------------------------------------
package pfcs_pkg;

  // Queue sizing.
  localparam int MAX_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int NQ_TOTAL    = MAX_QUEUES + 1;
  localparam int STORE_DEPTH = NQ_TOTAL * QUEUE_DEPTH;

  // Derived widths.
  localparam int QW      = $clog2(NQ_TOTAL);
  localparam int LS_W    = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int RR_W    = LS_W + 1;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int LEN_W   = 16;
  localparam int QB_W    = $clog2(QUEUE_DEPTH * 65535 + 1);

  // Field widths of the channels.
  localparam int MODE_W   = 3;
  localparam int QIDX_W   = 6;
  localparam int PFC_W    = 2;
  localparam int STATUS_W = 3;
  localparam int SQ_W     = 4;
  localparam int TP_W     = 10;
  localparam int TB_W     = 26;
  localparam int BYTE_W   = 48;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_QUEUES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_THROUGH = 1'd1;

  // Event codes.
  localparam logic [MODE_W-1:0] MODE_ENQ_DATA = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ_CTRL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RX_PFC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RX_OTHER = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEQUEUE  = 3'd4;

  // PFC frame types.
  localparam logic [PFC_W-1:0] PFC_PAUSE  = 2'd0;
  localparam logic [PFC_W-1:0] PFC_RESUME = 2'd1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_PFC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [QIDX_W-1:0] queue_index;
    logic [LEN_W-1:0]  packet_length;
    logic [PFC_W-1:0]  pfc_type;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                grant;
    logic [SQ_W-1:0]     served_queue;
    logic [LEN_W-1:0]    served_length;
    logic                forward_up;
    logic                transmit_kick;
    logic [TP_W-1:0]     queued_packets;
    logic [TB_W-1:0]     queued_bytes;
    logic [BYTE_W-1:0]   rx_byte_total;
    logic [BYTE_W-1:0]   tx_byte_total;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the accepted input beat
    logic eval;         // decode the item, select a queue, start the store read
    logic commit_exec;  // finish an item that needs no store read
    logic commit_pop;   // finish a dequeue with the read length
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_needed;   // the item is a dequeue that found a packet
    logic out_free;     // the output register can take a result this cycle
  } dp_status_t;

endpackage

// File: hw/rtl/pfcs_ram.sv
// ----------------------------------------------------------------------------
// pfcs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfcs_ram #(
  parameter int  WIDTH  = 16,
  parameter int  DEPTH  = 576,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/pfcs_ctrl.sv
// ----------------------------------------------------------------------------
// pfcs_ctrl: sequencer of the PFC egress scheduler
// Takes one input beat at a time, steps it through decode and, for a served
// dequeue, the store read, and finishes it once the output register is free.
// ----------------------------------------------------------------------------
module pfcs_ctrl
  import pfcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.eval = 1'b1;
        if (status.pop_needed) begin
          state_next = S_POP;
        end else if (status.out_free) begin
          cmd.commit_exec = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_POP: begin
        if (status.out_free) begin
          cmd.commit_pop = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/pfcs_datapath.sv
// ----------------------------------------------------------------------------
// pfcs_datapath: queue state, scheduler and result register
// Keeps the per-queue pointers, counts and pause flags, the totals, the
// length store and the rotating search for the next data queue to serve.
// ----------------------------------------------------------------------------
module pfcs_datapath
  import pfcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status
);

  // Configuration.
  logic [CFG_DATA_W-1:0] num_queues;
  logic                  pass_through;

  // Queue state.
  logic [PTR_W-1:0] head     [NQ_TOTAL];
  logic [PTR_W-1:0] tail     [NQ_TOTAL];
  logic [CNT_W-1:0] qcnt     [NQ_TOTAL];
  logic [QB_W-1:0]  qbytes   [NQ_TOTAL];
  logic [NQ_TOTAL-1:0] paused;
  logic [LS_W-1:0]  last_served;
  logic [TP_W-1:0]  total_packets;
  logic [TB_W-1:0]  total_bytes;
  logic [BYTE_W-1:0] rx_bytes;
  logic [BYTE_W-1:0] tx_bytes;

  // Item under work.
  in_item_t         item;
  logic [QW-1:0]    sel_q;
  logic             sel_ctrl;

  // Decode results.
  logic [QW-1:0]       eff_n;
  logic                qidx_in_range;
  logic [QW-1:0]       enq_q;
  logic                enq_full;
  logic [QW-1:0]       pfc_class;
  logic                ctrl_ready;
  logic [MAX_QUEUES-1:0] elig;
  logic [RR_W-1:0]     rr_pos;
  logic                rr_found;
  logic [QW-1:0]       rr_q;
  logic                deq_grant;
  logic [QW-1:0]       deq_q;
  logic                enq_do;
  logic                pause_do;
  logic                rx_do;
  logic [STATUS_W-1:0] exec_status;
  logic                exec_fwd;
  logic                exec_kick;
  logic [TP_W-1:0]     tp_exec;
  logic [TB_W-1:0]     tb_exec;
  logic [BYTE_W-1:0]   rx_exec;
  out_item_t           exec_out;

  // Dequeue completion.
  logic [LEN_W-1:0]    pop_len;
  out_item_t           pop_out;

  // Store ports.
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;

  function automatic logic [PTR_W-1:0] ptr_bump(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W + 1)'(1);
    return (int'(s) >= QUEUE_DEPTH) ? '0 : s[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [QW-1:0] q,
                                                   input logic [PTR_W-1:0] p);
    return ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p));
  endfunction

  // Effective queue count and the queue each event refers to.
  always_comb begin
    eff_n         = (int'(num_queues) > MAX_QUEUES) ? QW'(MAX_QUEUES) : QW'(num_queues);
    qidx_in_range = int'(item.queue_index) < int'(eff_n);
    enq_q         = (item.mode == MODE_ENQ_DATA) ? QW'(item.queue_index) : eff_n;
    enq_full      = int'(qcnt[enq_q]) >= QUEUE_DEPTH;
    pfc_class     = qidx_in_range ? QW'(item.queue_index) : eff_n;
  end

  // Scheduler: control queue first, then a rotating search that starts
  // just after the last data queue served.
  always_comb begin
    for (int q = 0; q < MAX_QUEUES; q++) begin
      elig[q] = (q < int'(eff_n)) && !paused[q] && (qcnt[q] != '0);
    end
    ctrl_ready = (qcnt[eff_n] != '0) && !paused[eff_n];
    rr_found   = 1'b0;
    rr_q       = '0;
    rr_pos     = '0;
    for (int k = 0; k < MAX_QUEUES; k++) begin
      rr_pos = {1'b0, last_served} + RR_W'(k + 1);
      if (int'(rr_pos) >= MAX_QUEUES) begin
        rr_pos = rr_pos - RR_W'(MAX_QUEUES);
      end
      if (!rr_found && elig[rr_pos[LS_W-1:0]]) begin
        rr_found = 1'b1;
        rr_q     = QW'(rr_pos[LS_W-1:0]);
      end
    end
    deq_grant = ctrl_ready || rr_found;
    deq_q     = ctrl_ready ? eff_n : rr_q;
  end

  // Event decode for items finished without a store read.
  always_comb begin
    enq_do      = 1'b0;
    pause_do    = 1'b0;
    rx_do       = 1'b0;
    exec_status = ST_OK;
    exec_fwd    = 1'b0;
    exec_kick   = 1'b0;
    unique case (item.mode)
      MODE_ENQ_DATA: begin
        if (!qidx_in_range) begin
          exec_status = ST_OUT_RANGE;
        end else if (enq_full) begin
          exec_status = ST_FULL;
        end else begin
          enq_do = 1'b1;
        end
      end
      MODE_ENQ_CTRL: begin
        if (enq_full) begin
          exec_status = ST_FULL;
        end else begin
          enq_do = 1'b1;
        end
      end
      MODE_RX_PFC: begin
        rx_do = 1'b1;
        if (item.pfc_type > PFC_RESUME) begin
          exec_status = ST_BAD_PFC;
        end else begin
          pause_do  = 1'b1;
          exec_kick = (item.pfc_type == PFC_RESUME);
          exec_fwd  = pass_through;
        end
      end
      MODE_RX_OTHER: begin
        rx_do    = 1'b1;
        exec_fwd = 1'b1;
      end
      MODE_DEQUEUE: begin
        if (!deq_grant) begin
          exec_status = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase

    tp_exec = enq_do ? total_packets + TP_W'(1) : total_packets;
    tb_exec = enq_do ? total_bytes + TB_W'(item.packet_length) : total_bytes;
    rx_exec = rx_do ? rx_bytes + BYTE_W'(item.packet_length) : rx_bytes;

    exec_out.status         = exec_status;
    exec_out.grant          = 1'b0;
    exec_out.served_queue   = '0;
    exec_out.served_length  = '0;
    exec_out.forward_up     = exec_fwd;
    exec_out.transmit_kick  = exec_kick;
    exec_out.queued_packets = tp_exec;
    exec_out.queued_bytes   = tb_exec;
    exec_out.rx_byte_total  = rx_exec;
    exec_out.tx_byte_total  = tx_bytes;
  end

  // Result of a served dequeue, using the length read from the store.
  always_comb begin
    pop_out.status         = ST_OK;
    pop_out.grant          = 1'b1;
    pop_out.served_queue   = SQ_W'(sel_q);
    pop_out.served_length  = pop_len;
    pop_out.forward_up     = 1'b0;
    pop_out.transmit_kick  = 1'b0;
    pop_out.queued_packets = total_packets - TP_W'(1);
    pop_out.queued_bytes   = total_bytes - TB_W'(pop_len);
    pop_out.rx_byte_total  = rx_bytes;
    pop_out.tx_byte_total  = tx_bytes + BYTE_W'(pop_len);
  end

  // Handshake status toward the controller.
  always_comb begin
    status.pop_needed = (item.mode == MODE_DEQUEUE) && deq_grant;
    status.out_free   = !out_valid || !out_stall;
  end

  // Length store: enqueues write at the tail, dequeues read at the head.
  always_comb begin
    wr_en   = cmd.commit_exec && enq_do;
    wr_addr = store_addr(enq_q, tail[enq_q]);
    rd_en   = cmd.eval && status.pop_needed;
    rd_addr = store_addr(deq_q, head[deq_q]);
  end

  pfcs_ram #(
    .WIDTH (LEN_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item.packet_length),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (pop_len)
  );

  // State updates, result register and configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_queues    <= '0;
      pass_through  <= 1'b0;
      for (int q = 0; q < NQ_TOTAL; q++) begin
        head[q]   <= '0;
        tail[q]   <= '0;
        qcnt[q]   <= '0;
        qbytes[q] <= '0;
      end
      paused        <= '0;
      last_served   <= '0;
      total_packets <= '0;
      total_bytes   <= '0;
      rx_bytes      <= '0;
      tx_bytes      <= '0;
      out_valid     <= 1'b0;
    end else begin
      // The result register fills on a finish and empties when taken.
      if (cmd.commit_exec || cmd.commit_pop) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cmd.load) begin
        item <= in_data;
      end

      if (cmd.eval) begin
        sel_q    <= deq_q;
        sel_ctrl <= ctrl_ready;
      end

      // Finish an enqueue, receive, refused or empty event.
      if (cmd.commit_exec) begin
        out_data  <= exec_out;
        if (enq_do) begin
          tail[enq_q]   <= ptr_bump(tail[enq_q]);
          qcnt[enq_q]   <= qcnt[enq_q] + CNT_W'(1);
          qbytes[enq_q] <= qbytes[enq_q] + QB_W'(item.packet_length);
        end
        if (pause_do) begin
          paused[pfc_class] <= (item.pfc_type == PFC_PAUSE);
        end
        total_packets <= tp_exec;
        total_bytes   <= tb_exec;
        rx_bytes      <= rx_exec;
      end

      // Finish a served dequeue.
      if (cmd.commit_pop) begin
        out_data      <= pop_out;
        head[sel_q]   <= ptr_bump(head[sel_q]);
        qcnt[sel_q]   <= qcnt[sel_q] - CNT_W'(1);
        qbytes[sel_q] <= qbytes[sel_q] - QB_W'(pop_len);
        total_packets <= pop_out.queued_packets;
        total_bytes   <= pop_out.queued_bytes;
        tx_bytes      <= pop_out.tx_byte_total;
        if (!sel_ctrl) begin
          last_served <= sel_q[LS_W-1:0];
        end
      end

      // A new queue count empties every queue and clears all pauses.
      if (cfg_write) begin
        unique case (cfg_index)
          REG_NUM_QUEUES: begin
            num_queues <= cfg_data;
            for (int q = 0; q < NQ_TOTAL; q++) begin
              head[q]   <= '0;
              tail[q]   <= '0;
              qcnt[q]   <= '0;
              qbytes[q] <= '0;
            end
            paused        <= '0;
            last_served   <= '0;
            total_packets <= '0;
            total_bytes   <= '0;
          end
          REG_PASS_THROUGH: begin
            pass_through <= cfg_data[0];
          end
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/pfc_priority_queue_scheduler_unit.sv
// ----------------------------------------------------------------------------
// pfc_priority_queue_scheduler_unit: PFC pausable round-robin egress scheduler
// Queues packet lengths per class, honors PFC pause and resume, and serves the
// control queue first and the data queues in round-robin order.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is one event: a data or control enqueue, a received PFC
//   frame, another received frame, or a dequeue request. Every event yields
//   exactly one result beat with a status, the served packet for a dequeue,
//   the forward and kick flags, and the running totals after the event.
//   Both channels use valid and stall; a beat moves when valid is high and
//   stall is low. The configuration port takes a write whenever cfg_write is
//   high; write it only while no event is in flight.
//   Sequencing: one event is worked at a time. A non-dequeue event and a dequeue
//   that finds nothing are loaded, then evaluated and finished; a served
//   dequeue adds a step for the registered read of the length store before
//   it finishes.
//   The output register lets the next event be accepted while a result
//   waits; an event then holds in its last step until the result register
//   is taken.
//   Reset (synchronous) empties all queues, clears every pause, the totals
//   and both registers. The length store is not cleared; the counts keep
//   unwritten entries from being read.
// ----------------------------------------------------------------------------
module pfc_priority_queue_scheduler_unit
  import pfcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  pfcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Queue state, scheduler and result register.
  pfcs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: sim/tb_pfc_priority_queue_scheduler_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pfc_priority_queue_scheduler_unit: self-checking bench for the PFC egress scheduler
// Drives enqueue, PFC, receive and dequeue events through the valid/stall
// channels under several queue counts and pass-through settings, predicts
// every result beat in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
module tb_pfc_priority_queue_scheduler_unit;
  import pfcs_pkg::*;

  localparam int CLK_HIGH       = 6;
  localparam int CLK_LOW        = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_CAP     = 200;
  localparam int NUM_PHASES     = 8;

  // Event and frame type codes the package leaves unnamed.
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [PFC_W-1:0]  PFC_INVALID_LO   = 2'd2;
  localparam logic [PFC_W-1:0]  PFC_INVALID_HI   = 2'd3;

  typedef enum int {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } traffic_mix_t;

  typedef struct {
    int           nq;
    bit           pt;
    bit           keep_nq;
    traffic_mix_t mix;
    int           count;
    int           snd_pct;
    int           rcv_pct;
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  int snd_idle_pct = 11;
  int rcv_idle_pct = 75;
  int idle_run;

  // Scoreboard: tracks queue state and holds the results still owed.
  class egress_scoreboard;
    logic [LEN_W-1:0]  len_mem [NQ_TOTAL][QUEUE_DEPTH];
    int unsigned       head_q [NQ_TOTAL];
    int unsigned       tail_q [NQ_TOTAL];
    int unsigned       pkt_q [NQ_TOTAL];
    int unsigned       byte_q [NQ_TOTAL];
    bit                held [NQ_TOTAL];
    int unsigned       last_rr;
    int unsigned       pkt_total;
    int unsigned       byte_total;
    logic [BYTE_W-1:0] rx_total;
    logic [BYTE_W-1:0] tx_total;
    logic [3:0]        nq_reg;
    bit                pt_reg;
    out_item_t         pending_outcomes [$];
    int unsigned       errors;
    int unsigned       events;
    int unsigned       results;
    int unsigned       grants;
    int unsigned       settings;
    int unsigned       status_seen [8];

    function new();
      clear_queues();
      rx_total = '0;
      tx_total = '0;
      nq_reg   = '0;
      pt_reg   = 1'b0;
      errors   = 0;
      events   = 0;
      results  = 0;
      grants   = 0;
      settings = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Empty every queue and lift every pause; rx and tx byte totals survive.
    function void clear_queues();
      for (int q = 0; q < NQ_TOTAL; q++) begin
        head_q[q] = 0;
        tail_q[q] = 0;
        pkt_q[q]  = 0;
        byte_q[q] = 0;
        held[q]   = 1'b0;
      end
      last_rr    = 0;
      pkt_total  = 0;
      byte_total = 0;
    endfunction

    function int unsigned eff_queues();
      return (nq_reg > MAX_QUEUES) ? MAX_QUEUES : nq_reg;
    endfunction

    function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_NUM_QUEUES) begin
        nq_reg = val;
        clear_queues();
        settings++;
      end else if (idx == REG_PASS_THROUGH) begin
        pt_reg = val[0];
      end
    endfunction

    function logic [STATUS_W-1:0] push_length(int unsigned q, logic [LEN_W-1:0] len);
      if (pkt_q[q] >= QUEUE_DEPTH) return ST_FULL;
      len_mem[q][tail_q[q]] = len;
      tail_q[q] = (tail_q[q] + 1 >= QUEUE_DEPTH) ? 0 : tail_q[q] + 1;
      pkt_q[q]++;
      byte_q[q]  += len;
      pkt_total++;
      byte_total += len;
      return ST_OK;
    endfunction

    function logic [LEN_W-1:0] pop_length(int unsigned q);
      logic [LEN_W-1:0] len;
      len = len_mem[q][head_q[q]];
      head_q[q] = (head_q[q] + 1 >= QUEUE_DEPTH) ? 0 : head_q[q] + 1;
      pkt_q[q]--;
      byte_q[q]  -= len;
      pkt_total--;
      byte_total -= len;
      tx_total = tx_total + BYTE_W'(len);
      return len;
    endfunction

    // Work out the result beat of one event and update the queue state.
    function out_item_t schedule_event(in_item_t ev);
      out_item_t   r;
      int unsigned n;
      int unsigned cls;
      int unsigned q;
      int unsigned i;
      bit          found;
      r = '0;
      n = eff_queues();
      case (ev.mode)
        MODE_ENQ_DATA: begin
          if (ev.queue_index >= n) r.status = ST_OUT_RANGE;
          else r.status = push_length(ev.queue_index, ev.packet_length);
        end
        MODE_ENQ_CTRL: begin
          r.status = push_length(n, ev.packet_length);
        end
        MODE_RX_PFC: begin
          rx_total = rx_total + BYTE_W'(ev.packet_length);
          if (ev.pfc_type != PFC_PAUSE && ev.pfc_type != PFC_RESUME) begin
            r.status = ST_BAD_PFC;
          end else begin
            // Classes beyond the data queues land on the control queue.
            cls = (ev.queue_index >= n) ? n : ev.queue_index;
            held[cls] = (ev.pfc_type == PFC_PAUSE);
            r.transmit_kick = (ev.pfc_type == PFC_RESUME);
            r.forward_up = pt_reg;
          end
        end
        MODE_RX_OTHER: begin
          rx_total = rx_total + BYTE_W'(ev.packet_length);
          r.forward_up = 1'b1;
        end
        MODE_DEQUEUE: begin
          found = 1'b0;
          if (pkt_q[n] > 0 && !held[n]) begin
            found = 1'b1;
            r.served_queue  = SQ_W'(n);
            r.served_length = pop_length(n);
          end else begin
            // Round robin over data queues, starting after the last one served.
            for (i = 1; i <= n; i++) begin
              q = (last_rr + i) % n;
              if (!found && !held[q] && pkt_q[q] > 0) begin
                found = 1'b1;
                r.served_queue  = SQ_W'(q);
                r.served_length = pop_length(q);
                last_rr = q;
              end
            end
          end
          r.grant = found;
          if (!found) r.status = ST_EMPTY;
        end
        default: ;
      endcase
      r.queued_packets = TP_W'(pkt_total);
      r.queued_bytes   = TB_W'(byte_total);
      r.rx_byte_total  = rx_total;
      r.tx_byte_total  = tx_total;
      return r;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t outcome;
      outcome = schedule_event(ev);
      pending_outcomes.insert(pending_outcomes.size(), outcome);
      events++;
    endfunction

    function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        if (errors < REPORT_CAP)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t want;
      results++;
      if (pending_outcomes.size() == 0) begin
        if (errors < REPORT_CAP)
          $display("%0t: result beat with nothing expected, expected none, actual %p",
                   $time, got);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (want.grant) grants++;
      status_seen[want.status]++;
      compare_field("status", want.status, got.status);
      compare_field("grant", want.grant, got.grant);
      compare_field("served_queue", want.served_queue, got.served_queue);
      compare_field("served_length", want.served_length, got.served_length);
      compare_field("forward_up", want.forward_up, got.forward_up);
      compare_field("transmit_kick", want.transmit_kick, got.transmit_kick);
      compare_field("queued_packets", want.queued_packets, got.queued_packets);
      compare_field("queued_bytes", want.queued_bytes, got.queued_bytes);
      compare_field("rx_byte_total", want.rx_byte_total, got.rx_byte_total);
      compare_field("tx_byte_total", want.tx_byte_total, got.tx_byte_total);
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction
  endclass

  egress_scoreboard sb;

  pfc_priority_queue_scheduler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock, 12 ns period.
  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  // Receiver back-pressure at the rate set for the current stretch.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  // Beat monitor: note accepted events, check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_event(in_data);
      if (out_valid && !out_stall) sb.check_outcome(out_data);
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  initial begin
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("Watchdog expired at %0t with no beat moving", $time);
    $display("FAIL");
    $finish;
  end

  // Present one event beat, with random sender gaps, until it is taken.
  task automatic send_event(in_item_t ev);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_fields(logic [MODE_W-1:0] mode, int qidx, int len,
                             logic [PFC_W-1:0] ptype);
    in_item_t ev;
    ev.mode          = mode;
    ev.queue_index   = QIDX_W'(qidx);
    ev.packet_length = LEN_W'(len);
    ev.pfc_type      = ptype;
    send_event(ev);
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Optional queue-count write, then the pass-through write; the enable stays high across both.
  task automatic write_settings(bit with_nq, logic [CFG_DATA_W-1:0] nq,
                                logic [CFG_DATA_W-1:0] pt);
    if (with_nq) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_NUM_QUEUES;
      cfg_data  <= nq;
      @(posedge clk);
      sb.apply_setting(REG_NUM_QUEUES, nq);
    end
    cfg_write <= 1'b1;
    cfg_index <= REG_PASS_THROUGH;
    cfg_data  <= pt;
    @(posedge clk);
    sb.apply_setting(REG_PASS_THROUGH, pt);
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed traffic for n data queues, plus some noise.
  function automatic in_item_t random_event(int n, traffic_mix_t mix);
    in_item_t ev;
    int       pick;
    int       len_pick;
    int       type_pick;
    int       d_hi;
    int       c_hi;
    int       p_hi;
    int       o_hi;
    int       q_hi;
    case (mix)
      MIX_FILL: begin
        d_hi = 40; c_hi = 80; p_hi = 88; o_hi = 92; q_hi = 98;
      end
      MIX_DRAIN: begin
        d_hi = 20; c_hi = 25; p_hi = 35; o_hi = 40; q_hi = 98;
      end
      default: begin
        d_hi = 30; c_hi = 40; p_hi = 52; o_hi = 60; q_hi = 96;
      end
    endcase
    ev.queue_index = QIDX_W'($urandom_range(63));
    ev.pfc_type    = PFC_W'($urandom_range(3));
    len_pick = $urandom_range(99);
    if (len_pick < 10) ev.packet_length = '0;
    else if (len_pick < 20) ev.packet_length = '1;
    else ev.packet_length = LEN_W'($urandom);
    pick = $urandom_range(99);
    if (pick < d_hi) begin
      ev.mode = MODE_ENQ_DATA;
      if (n > 0 && $urandom_range(99) < 85) ev.queue_index = QIDX_W'($urandom_range(n - 1));
    end else if (pick < c_hi) begin
      ev.mode = MODE_ENQ_CTRL;
    end else if (pick < p_hi) begin
      ev.mode = MODE_RX_PFC;
      if ($urandom_range(99) < 70) ev.queue_index = QIDX_W'($urandom_range(n));
      type_pick = $urandom_range(99);
      if (type_pick < 40) ev.pfc_type = PFC_PAUSE;
      else if (type_pick < 90) ev.pfc_type = PFC_RESUME;
      else ev.pfc_type = PFC_W'($urandom_range(PFC_INVALID_HI, PFC_INVALID_LO));
    end else if (pick < o_hi) begin
      ev.mode = MODE_RX_OTHER;
    end else if (pick < q_hi) begin
      ev.mode = MODE_DEQUEUE;
    end else begin
      ev.mode = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    end
    return ev;
  endfunction

  // Main sequence: reset, directed events, then randomized phases.
  initial begin
    phase_t plan [NUM_PHASES];
    int     p;
    int     k;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    sb = new();

    plan[0] = '{8,  1'b1, 1'b0, MIX_BALANCED, 200, 11, 75};
    plan[1] = '{0,  1'b0, 1'b0, MIX_FILL,     220, 11, 75};
    plan[2] = '{15, 1'b1, 1'b0, MIX_FILL,     230, 75, 11};
    plan[3] = '{1,  1'b0, 1'b0, MIX_BALANCED, 150, 75, 11};
    plan[4] = '{3,  1'b1, 1'b0, MIX_DRAIN,    150, 0,  0};
    plan[5] = '{5,  1'b0, 1'b0, MIX_BALANCED, 150, 0,  0};
    plan[6] = '{5,  1'b1, 1'b1, MIX_FILL,     100, 0,  0};
    plan[7] = '{2,  1'b0, 1'b0, MIX_FILL,     100, 0,  0};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed events with all eight data queues and pass-through on.
    write_settings(1'b1, 4'd8, 4'd1);
    send_fields(MODE_DEQUEUE, 0, 0, PFC_PAUSE);              // nothing queued yet
    send_fields(MODE_ENQ_DATA, 0, 0, PFC_PAUSE);
    send_fields(MODE_ENQ_DATA, 7, 16'hFFFF, PFC_RESUME);
    send_fields(MODE_ENQ_DATA, 8, 100, PFC_PAUSE);           // first queue index out of range
    send_fields(MODE_ENQ_DATA, 63, 16'hFFFF, PFC_INVALID_HI);
    send_fields(MODE_ENQ_CTRL, 0, 16'hFFFF, PFC_PAUSE);
    send_fields(MODE_ENQ_CTRL, 63, 1234, PFC_RESUME);
    send_fields(MODE_RX_PFC, 63, 64, PFC_PAUSE);             // clamps to control
    send_fields(MODE_RX_PFC, 0, 16'hFFFF, PFC_INVALID_LO);
    send_fields(MODE_RX_PFC, 63, 16'hFFFF, PFC_INVALID_HI);
    send_fields(MODE_DEQUEUE, 0, 0, PFC_PAUSE);              // control paused: data q7
    send_fields(MODE_DEQUEUE, 0, 0, PFC_PAUSE);              // wraps to q0
    send_fields(MODE_DEQUEUE, 0, 0, PFC_PAUSE);              // only paused control left
    send_fields(MODE_RX_PFC, 8, 60, PFC_RESUME);
    send_fields(MODE_RX_OTHER, 42, 16'hFFFF, PFC_INVALID_HI);
    send_fields(MODE_DEQUEUE, 0, 0, PFC_PAUSE);              // control first
    send_fields(MODE_RX_PFC, 3, 0, PFC_PAUSE);
    send_fields(MODE_ENQ_DATA, 3, 42, PFC_PAUSE);
    send_fields(MODE_ENQ_DATA, 5, 7, PFC_PAUSE);
    send_fields(MODE_DEQUEUE, 0, 0, PFC_PAUSE);              // control first, its remaining packet
    for (k = MODE_SPARE_FIRST; k <= MODE_SPARE_LAST; k++)
      send_fields(MODE_W'(k), 63, 16'hFFFF, PFC_INVALID_HI);
    send_fields(MODE_DEQUEUE, 0, 0, PFC_PAUSE);              // skips paused q3, serves q5
    send_fields(MODE_DEQUEUE, 0, 0, PFC_PAUSE);              // q3 still paused
    send_fields(MODE_RX_PFC, 3, 1500, PFC_RESUME);
    send_fields(MODE_DEQUEUE, 0, 0, PFC_PAUSE);

    // Randomized phases, each under its own register setting.
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_settings(!plan[p].keep_nq, CFG_DATA_W'(plan[p].nq), CFG_DATA_W'(plan[p].pt));
      snd_idle_pct = plan[p].snd_pct;
      rcv_idle_pct = plan[p].rcv_pct;
      for (k = 0; k < plan[p].count; k++)
        send_event(random_event(sb.eff_queues(), plan[p].mix));
    end
    drain_results();

    $display("Covered %0d events and %0d result beats across %0d queue-count settings.",
             sb.events, sb.results, sb.settings);
    $display("Grants %0d, out-of-range %0d, full %0d, bad PFC %0d, empty dequeues %0d.",
             sb.grants, sb.status_seen[ST_OUT_RANGE], sb.status_seen[ST_FULL],
             sb.status_seen[ST_BAD_PFC], sb.status_seen[ST_EMPTY]);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
